// File: rtl/radix_prefixed_number_parser_macros.svh
// ============================================================================
// Assertion macros for the radix prefixed number parser
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ============================================================================
`ifndef RADIX_PREFIXED_NUMBER_PARSER_MACROS_SVH
`define RADIX_PREFIXED_NUMBER_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPNP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpnp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPNP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpnp: next-cycle check failed");

`endif

// File: rtl/rpnp_pkg.sv
// ============================================================================
// rpnp_pkg
// Types, character codes and the digit decoder for the number parser.
// ============================================================================
package rpnp_pkg;

    localparam int ValueBits   = 16;
    localparam int CharBits    = 8;
    localparam int BaseBits    = 6;
    localparam int OutDataBits = ((ValueBits + CharBits + 7) / 8) * 8;

    typedef logic [ValueBits-1:0] t_val;
    typedef logic [CharBits-1:0]  t_char;
    typedef logic [BaseBits-1:0]  t_base;
    typedef logic [1:0]           t_phase;

    localparam t_phase PhSkip   = 2'd0;
    localparam t_phase PhZero   = 2'd1;
    localparam t_phase PhDigits = 2'd2;

    localparam t_char CharNul    = 8'h00;
    localparam t_char CharSpace  = 8'h20;
    localparam t_char CharDollar = 8'h24;
    localparam t_char CharAmp    = 8'h26;
    localparam t_char CharUpX    = 8'h58;
    localparam t_char CharHash   = 8'h23;
    localparam t_char CharPct    = 8'h25;
    localparam t_char CharDash   = 8'h2d;
    localparam t_char CharZero   = 8'h30;
    localparam t_char CharNine   = 8'h39;
    localparam t_char CharLowA   = 8'h61;
    localparam t_char CharLowZ   = 8'h7a;
    localparam t_char CharUpA    = 8'h41;
    localparam t_char CharUpZ    = 8'h5a;

    localparam t_base BaseHex     = 6'd16;
    localparam t_base BaseDec     = 6'd10;
    localparam t_base BaseBin     = 6'd2;
    localparam t_base BaseNone    = 6'd0;
    localparam t_base DigitNone   = 6'd63;
    localparam t_base LetterValue = 6'd10;

    typedef struct packed {
        t_phase phase;
        t_base  base;
        t_val   acc;
        logic   found;
    } t_state;

    typedef struct packed {
        logic  emit;
        t_val  value;
        logic  found;
        logic  dash_seen;
        t_char stop_char;
    } t_result;

    // Digit value of a character, DigitNone when it is no digit. DigitNone is
    // never below a six-bit base, so one compare decides validity.
    function automatic t_base digit_of(input t_char c);
        t_base d;
        d = DigitNone;
        if (c >= CharZero && c <= CharNine) begin
            d = BaseBits'(c - CharZero);
        end else if (c >= CharLowA && c <= CharLowZ) begin
            d = BaseBits'(c - CharLowA) + LetterValue;
        end else if (c >= CharUpA && c <= CharUpZ) begin
            d = BaseBits'(c - CharUpA) + LetterValue;
        end
        return d;
    endfunction

endpackage

// File: rtl/radix_prefixed_number_parser.sv
// ============================================================================
// radix_prefixed_number_parser
// Streaming parser of unsigned numbers with radix prefixes, one byte a request.
// ============================================================================
// The block takes one character in every clock cycle and keeps taking them
// without gaps while the output is read. A character first lands in an input
// register. From there a single multiply-add and compare updates the parse
// state and, when a number ends, loads the result register, which follows
// the input register. The parse state loop closes through that multiply-add,
// which sets the rate of one character per cycle while the output is read.
// Input stalls whenever a finished result waits unread at the output while a
// character is held in the input register.
module radix_prefixed_number_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,    // default_base
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [rpnp_pkg::OutDataBits-1:0] m_axis_tdata, // value, stop_char
    output logic [1:0]  m_axis_tuser   // found, dash_seen
);

`include "radix_prefixed_number_parser_macros.svh"

    logic              r_in_valid;
    rpnp_pkg::t_char   r_char;
    rpnp_pkg::t_state  r_state;
    rpnp_pkg::t_state  n_state;
    rpnp_pkg::t_base   r_default_base;
    logic              r_out_valid;
    rpnp_pkg::t_result r_out;
    rpnp_pkg::t_result w_result;
    logic              w_fire;

    rpnp_step u_step (
        .i_state       (r_state),
        .i_char        (r_char),
        .i_default_base(r_default_base),
        .o_state       (n_state),
        .o_result      (w_result)
    );

    assign o_cfg_ready   = 1'b1;
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.dash_seen, r_out.found};

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[rpnp_pkg::ValueBits-1:0] = r_out.value;
        m_axis_tdata[rpnp_pkg::ValueBits +: rpnp_pkg::CharBits] = r_out.stop_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_base <= rpnp_pkg::BaseHex;
        end else if (i_cfg_valid) begin
            r_default_base <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_char <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= rpnp_pkg::PhSkip;
            r_state.base  <= rpnp_pkg::BaseHex;
            r_state.acc   <= '0;
            r_state.found <= 1'b0;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_result.emit) begin
            r_out <= w_result;
        end
    end

    `RPNP_ASSERT_SAME(a_no_digit_zero_value,
        r_out_valid && !r_out.found, r_out.value == '0)
    `RPNP_ASSERT_SAME(a_dash_result,
        r_out_valid && r_out.dash_seen,
        !r_out.found && r_out.stop_char == rpnp_pkg::CharDash)
    `RPNP_ASSERT_NEXT(a_restart_after_result,
        w_fire && w_result.emit,
        r_state.phase == rpnp_pkg::PhSkip && r_state.acc == '0 && !r_state.found)
    `RPNP_ASSERT_NEXT(a_held_char_kept,
        r_in_valid && !w_fire, r_in_valid && $stable(r_char))

endmodule

// File: rtl/rpnp_step.sv
// ============================================================================
// rpnp_step
// Next parser state and optional result for one character.
// ============================================================================
module rpnp_step (
    input  rpnp_pkg::t_state  i_state,
    input  rpnp_pkg::t_char   i_char,
    input  rpnp_pkg::t_base   i_default_base,
    output rpnp_pkg::t_state  o_state,
    output rpnp_pkg::t_result o_result
);

    logic             take;
    rpnp_pkg::t_base  td_base;
    rpnp_pkg::t_val   td_acc;
    logic             td_found;
    rpnp_pkg::t_base  digit;
    rpnp_pkg::t_val   product;
    rpnp_pkg::t_state stay;
    rpnp_pkg::t_state restart;

    assign digit   = rpnp_pkg::digit_of(i_char);
    assign product = rpnp_pkg::ValueBits'(td_acc * rpnp_pkg::t_val'(td_base));

    always_comb begin
        restart.phase = rpnp_pkg::PhSkip;
        restart.base  = i_default_base;
        restart.acc   = '0;
        restart.found = 1'b0;

        stay     = i_state;
        take     = 1'b0;
        td_base  = i_state.base;
        td_acc   = i_state.acc;
        td_found = i_state.found;
        o_result = '0;
        o_state  = i_state;

        unique case (i_state.phase)
            rpnp_pkg::PhDigits: begin
                take = 1'b1;
            end
            rpnp_pkg::PhZero: begin
                if (i_char == rpnp_pkg::CharUpX) begin
                    o_state.phase = rpnp_pkg::PhDigits;
                    o_state.base  = rpnp_pkg::BaseHex;
                end else if (i_default_base == rpnp_pkg::BaseNone) begin
                    o_result.emit      = 1'b1;
                    o_result.stop_char = rpnp_pkg::CharZero;
                    o_state            = restart;
                end else begin
                    take     = 1'b1;
                    td_base  = i_default_base;
                    td_acc   = '0;
                    td_found = 1'b1;
                end
            end
            default: begin
                if (i_char == rpnp_pkg::CharNul) begin
                    o_result.emit = 1'b1;
                    o_state       = restart;
                end else if (i_char > rpnp_pkg::CharSpace) begin
                    stay.acc   = '0;
                    stay.found = 1'b0;
                    stay.phase = rpnp_pkg::PhDigits;
                    unique case (i_char) inside
                        rpnp_pkg::CharDollar, rpnp_pkg::CharAmp, rpnp_pkg::CharUpX: begin
                            stay.base = rpnp_pkg::BaseHex;
                            o_state   = stay;
                        end
                        rpnp_pkg::CharHash: begin
                            stay.base = rpnp_pkg::BaseDec;
                            o_state   = stay;
                        end
                        rpnp_pkg::CharPct: begin
                            stay.base = rpnp_pkg::BaseBin;
                            o_state   = stay;
                        end
                        rpnp_pkg::CharZero: begin
                            stay.phase = rpnp_pkg::PhZero;
                            o_state    = stay;
                        end
                        rpnp_pkg::CharDash: begin
                            o_result.emit      = 1'b1;
                            o_result.dash_seen = 1'b1;
                            o_result.stop_char = rpnp_pkg::CharDash;
                            o_state            = restart;
                        end
                        default: begin
                            take     = 1'b1;
                            td_base  = i_default_base;
                            td_acc   = '0;
                            td_found = 1'b0;
                        end
                    endcase
                end
            end
        endcase

        if (take) begin
            if (digit < td_base) begin
                o_state.phase = rpnp_pkg::PhDigits;
                o_state.base  = td_base;
                o_state.acc   = product + rpnp_pkg::t_val'(digit);
                o_state.found = 1'b1;
            end else begin
                o_result.emit      = 1'b1;
                o_result.value     = td_found ? td_acc : '0;
                o_result.found     = td_found;
                o_result.stop_char = i_char;
                o_state            = restart;
            end
        end
    end

endmodule
